// File: hdl/dba_pkg.sv
package dba_pkg;

	localparam int NUM_BLOCKS = 256;
	localparam int MAX_RUN    = 63;
	localparam int BLK_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = BLK_W + 1;
	localparam int LEN_W      = 6;
	localparam int FND_AW     = $clog2(MAX_RUN);
	localparam int SIZE_W     = 9;
	localparam int OP_W       = 3;
	localparam int KIND_W     = 2;
	localparam int SIZE_RESET = 256;

	typedef enum logic [OP_W-1:0] {
		OP_SET     = 3'd0,
		OP_CONTIG  = 3'd1,
		OP_INDEXED = 3'd2,
		OP_LINKED  = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE  = 2'd0,
		KIND_INDEX = 2'd1,
		KIND_DATA  = 2'd2,
		KIND_MARK  = 2'd3
	} kind_t;

	typedef struct packed {
		logic              status;
		kind_t             kind;
		logic [BLK_W-1:0]  block;
		logic [BLK_W-1:0]  next_block;
		logic              has_next;
		logic              mark;
		logic              last;
	} res_t;

	// used map port: one write, one registered read
	typedef struct packed {
		logic              we;
		logic [BLK_W-1:0]  waddr;
		logic              wdata;
		logic [BLK_W-1:0]  raddr;
	} map_req_t;

	// found list port
	typedef struct packed {
		logic              we;
		logic [FND_AW-1:0] waddr;
		logic [BLK_W-1:0]  wdata;
		logic [FND_AW-1:0] raddr;
	} fnd_req_t;

endpackage

// File: hdl/dba_req_if.sv
interface dba_req_if;
	logic                        valid;
	logic                        ready;
	logic [dba_pkg::OP_W-1:0]    operation;
	logic [dba_pkg::BLK_W-1:0]   block_number;
	logic [dba_pkg::LEN_W-1:0]   length;
	logic                        mark_value;

	modport source (output valid, output operation, output block_number, output length,
		output mark_value, input ready);
	modport sink (input valid, input operation, input block_number, input length,
		input mark_value, output ready);
endinterface

// File: hdl/dba_rsp_if.sv
interface dba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic [dba_pkg::KIND_W-1:0]  kind;
	logic [dba_pkg::BLK_W-1:0]   block;
	logic [dba_pkg::BLK_W-1:0]   next_block;
	logic                        has_next;
	logic                        mark;
	logic                        last;

	modport source (output valid, output status, output kind, output block, output next_block,
		output has_next, output mark, output last, input ready);
	modport sink (input valid, input status, input kind, input block, input next_block,
		input has_next, input mark, input last, output ready);
endinterface

// File: hdl/dba_cfg_if.sv
interface dba_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [dba_pkg::SIZE_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/dba_ram.sv
module dba_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/dba_ctrl.sv
module dba_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	dba_req_if.sink                     req,
	dba_rsp_if.source                   rsp,
	input  logic [dba_pkg::CNT_W-1:0]   disk_n,
	output dba_pkg::map_req_t           map_req,
	input  logic                        map_rdata,
	output dba_pkg::fnd_req_t           fnd_req,
	input  logic [dba_pkg::BLK_W-1:0]   fnd_rdata
);

	typedef enum logic [10:0] {
		S_CLEAR = 11'b00000000001,
		S_IDLE  = 11'b00000000010,
		S_DISP  = 11'b00000000100,
		S_SCAN  = 11'b00000001000,
		S_CMARK = 11'b00000010000,
		S_IDX   = 11'b00000100000,
		S_FIRST = 11'b00001000000,
		S_GET   = 11'b00010000000,
		S_FETCH = 11'b00100000000,
		S_MARK  = 11'b01000000000,
		S_EMIT  = 11'b10000000000
	} state_t;

	state_t                         state_q, state_d;
	logic [dba_pkg::BLK_W-1:0]      clr_q;
	logic [dba_pkg::OP_W-1:0]       op_q;
	logic [dba_pkg::BLK_W-1:0]      bn_q;
	logic [dba_pkg::LEN_W-1:0]      len_q;
	logic [dba_pkg::CNT_W-1:0]      iss_q;
	logic [dba_pkg::CNT_W-1:0]      hi_q;
	logic                           chk_vld_s1;
	logic [dba_pkg::BLK_W-1:0]      chk_addr_s1;
	logic [dba_pkg::LEN_W-1:0]      got_q;
	logic                           skip_q;
	logic [dba_pkg::LEN_W-1:0]      idx_q;
	logic [dba_pkg::BLK_W-1:0]      cur_q;
	logic [dba_pkg::BLK_W-1:0]      nxt_q;
	dba_pkg::res_t                  res_q;

	logic                           req_acc;
	logic                           taken;
	logic                           col;
	logic                           got_all;
	logic                           drained;
	logic                           hit_free;
	logic                           hit_used;
	logic                           scan_go;
	logic [dba_pkg::CNT_W-1:0]      bn_end;
	logic [dba_pkg::LEN_W:0]        nxt_idx;
	logic                           more;
	logic                           lnk_more;
	logic                           contig_bad;
	logic                           idx_bad;
	logic                           lnk_bad;

	function automatic dba_pkg::res_t mk_res(
		input logic                      status,
		input dba_pkg::kind_t            kind,
		input logic [dba_pkg::BLK_W-1:0] block,
		input logic [dba_pkg::BLK_W-1:0] next_block,
		input logic                      has_next,
		input logic                      mark,
		input logic                      last
	);
		dba_pkg::res_t r;
		r.status     = status;
		r.kind       = kind;
		r.block      = block;
		r.next_block = next_block;
		r.has_next   = has_next;
		r.mark       = mark;
		r.last       = last;
		return r;
	endfunction

	assign req_acc = req.valid && req.ready;
	assign taken   = rsp.valid && rsp.ready;

	assign col      = (op_q != dba_pkg::OP_CONTIG);
	assign got_all  = col && (got_q == len_q);
	assign drained  = (iss_q >= hi_q) && !chk_vld_s1;
	assign hit_free = chk_vld_s1 && !map_rdata && !(skip_q && (chk_addr_s1 == bn_q));
	assign hit_used = chk_vld_s1 && map_rdata;
	assign scan_go  = !got_all && !drained && (col || !hit_used);

	assign bn_end   = dba_pkg::CNT_W'(bn_q) + dba_pkg::CNT_W'(len_q);
	assign nxt_idx  = {1'b0, idx_q} + 1'b1;
	assign more     = nxt_idx < {1'b0, len_q};
	assign lnk_more = more && (op_q == dba_pkg::OP_LINKED);

	assign contig_bad = (disk_n == '0) || (bn_end > disk_n);
	assign idx_bad    = (dba_pkg::CNT_W'(bn_q) >= disk_n) || map_rdata;
	assign lnk_bad    = (len_q == '0) || (disk_n == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == '1) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_acc && (req.operation != dba_pkg::OP_SET)) state_d = S_DISP;
			end
			S_DISP: begin
				unique case (op_q)
					dba_pkg::OP_READ:    state_d = S_EMIT;
					dba_pkg::OP_CONTIG:  state_d = contig_bad ? S_EMIT : S_SCAN;
					dba_pkg::OP_INDEXED: state_d = idx_bad ? S_EMIT : S_SCAN;
					dba_pkg::OP_LINKED:  state_d = lnk_bad ? S_EMIT : S_SCAN;
					default:             state_d = S_IDLE;
				endcase
			end
			S_SCAN: begin
				if (got_all) begin
					state_d = (op_q == dba_pkg::OP_INDEXED) ? S_IDX : S_FIRST;
				end else if (drained) begin
					state_d = (col || (len_q == '0)) ? S_EMIT : S_CMARK;
				end else if (!col && hit_used) begin
					state_d = S_EMIT;
				end
			end
			S_CMARK: state_d = S_EMIT;
			S_IDX:   state_d = S_EMIT;
			S_FIRST: state_d = S_GET;
			S_GET:   state_d = S_FETCH;
			S_FETCH: state_d = S_MARK;
			S_MARK:  state_d = S_EMIT;
			S_EMIT: begin
				if (taken) begin
					if (res_q.last) begin
						state_d = S_IDLE;
					end else if (op_q == dba_pkg::OP_CONTIG) begin
						state_d = S_CMARK;
					end else if (res_q.kind == dba_pkg::KIND_INDEX) begin
						state_d = S_FIRST;
					end else begin
						state_d = S_FETCH;
					end
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// memory ports
	always_comb begin
		map_req       = '0;
		fnd_req       = '0;
		// idle reads the requested block so the mark is ready in the dispatch state
		map_req.raddr = (state_q == S_IDLE) ? req.block_number : iss_q[dba_pkg::BLK_W-1:0];
		unique case (state_q)
			S_CLEAR: begin
				map_req.we    = 1'b1;
				map_req.waddr = clr_q;
				map_req.wdata = 1'b0;
			end
			S_IDLE: begin
				if (req_acc && (req.operation == dba_pkg::OP_SET)) begin
					map_req.we    = 1'b1;
					map_req.waddr = req.block_number;
					map_req.wdata = req.mark_value;
				end
			end
			S_SCAN: begin
				fnd_req.we    = scan_go && col && hit_free;
				fnd_req.waddr = dba_pkg::FND_AW'(got_q);
				fnd_req.wdata = chk_addr_s1;
			end
			S_CMARK: begin
				map_req.we    = 1'b1;
				map_req.waddr = bn_q + dba_pkg::BLK_W'(idx_q);
				map_req.wdata = 1'b1;
			end
			S_IDX: begin
				map_req.we    = 1'b1;
				map_req.waddr = bn_q;
				map_req.wdata = 1'b1;
			end
			S_FIRST: begin
				fnd_req.raddr = '0;
			end
			S_FETCH: begin
				// successor entry, only while one exists
				fnd_req.raddr = more ? dba_pkg::FND_AW'(nxt_idx) : dba_pkg::FND_AW'(idx_q);
			end
			S_MARK: begin
				map_req.we    = 1'b1;
				map_req.waddr = cur_q;
				map_req.wdata = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					op_q  <= req.operation;
					bn_q  <= req.block_number;
					len_q <= req.length;
				end
			end
			S_DISP: begin
				iss_q      <= (op_q == dba_pkg::OP_CONTIG) ? dba_pkg::CNT_W'(bn_q) : '0;
				hi_q       <= (op_q == dba_pkg::OP_CONTIG) ? bn_end : disk_n;
				got_q      <= '0;
				chk_vld_s1 <= 1'b0;
				skip_q     <= (op_q == dba_pkg::OP_INDEXED);
				idx_q      <= '0;
				res_q      <= (op_q == dba_pkg::OP_READ)
					? mk_res(1'b0, dba_pkg::KIND_MARK, bn_q, '0, 1'b0, map_rdata, 1'b1)
					: mk_res(1'b1, dba_pkg::KIND_NONE, '0, '0, 1'b0, 1'b0, 1'b1);
			end
			S_SCAN: begin
				// issue one map read per cycle, check the one issued last cycle
				if (iss_q < hi_q) begin
					chk_vld_s1  <= 1'b1;
					chk_addr_s1 <= iss_q[dba_pkg::BLK_W-1:0];
					iss_q       <= iss_q + 1'b1;
				end else begin
					chk_vld_s1  <= 1'b0;
				end
				if (fnd_req.we) got_q <= got_q + 1'b1;
				res_q <= (!col && drained && (len_q == '0))
					? mk_res(1'b0, dba_pkg::KIND_NONE, '0, '0, 1'b0, 1'b0, 1'b1)
					: mk_res(1'b1, dba_pkg::KIND_NONE, '0, '0, 1'b0, 1'b0, 1'b1);
			end
			S_CMARK: begin
				res_q <= mk_res(1'b0, dba_pkg::KIND_DATA, bn_q + dba_pkg::BLK_W'(idx_q), '0,
					1'b0, 1'b0, !more);
			end
			S_IDX: begin
				res_q <= mk_res(1'b0, dba_pkg::KIND_INDEX, bn_q, '0, 1'b0, 1'b0, len_q == '0);
			end
			S_GET: begin
				cur_q <= fnd_rdata;
			end
			S_MARK: begin
				nxt_q <= fnd_rdata;
				res_q <= mk_res(1'b0, dba_pkg::KIND_DATA, cur_q, lnk_more ? fnd_rdata : '0,
					lnk_more, 1'b0, !more);
			end
			S_EMIT: begin
				if (taken && !res_q.last) begin
					if (op_q == dba_pkg::OP_CONTIG) begin
						idx_q <= idx_q + 1'b1;
					end else if (res_q.kind != dba_pkg::KIND_INDEX) begin
						idx_q <= idx_q + 1'b1;
						cur_q <= nxt_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid      = (state_q == S_EMIT);
	assign rsp.status     = res_q.status;
	assign rsp.kind       = res_q.kind;
	assign rsp.block      = res_q.block;
	assign rsp.next_block = res_q.next_block;
	assign rsp.has_next   = res_q.has_next;
	assign rsp.mark       = res_q.mark;
	assign rsp.last       = res_q.last;

`ifndef ASSERT_OFF
	a_fnd_room: assert property (@(posedge clk) disable iff (!arst_n)
		fnd_req.we |-> (got_q != len_q))
		else $error("found list written past request length");

	a_got_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (got_q <= len_q))
		else $error("found count above request length");

	a_cmark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMARK) |-> (idx_q < len_q))
		else $error("contiguous marking beyond run");

	a_fail_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && res_q.status) |-> (res_q.last && (res_q.kind == dba_pkg::KIND_NONE)))
		else $error("failure beat is not a single final no-block beat");
`endif

endmodule

// File: hdl/disk_block_allocator.sv
// disk block allocator: used bitmap over disk blocks with allocation requests
// req channel: operation, block_number, length, mark_value; one request at a time,
//   ready is high only while the block is idle
// rsp channel: status, kind, block, next_block, has_next, mark, last; last marks the
//   final beat of a request, a failed request gives a single beat
// cfg channel: disk_size write data, always ready, write only while idle
// set mark: written on accept, no beat. read mark: beat valid after the dispatch state
// allocations scan the map one block per cycle through the map's single read port:
//   contiguous over its run of length blocks, indexed and linked up to disk_size blocks,
//   then each contiguous beat follows a marking state, the index beat follows the index
//   state, the first indexed or linked data beat follows the first, get, fetch and mark
//   states and each later one fetch and mark; a receiver holding ready low delays beats
// a stalled receiver holds the current beat; the sequencer waits with it
// reset: disk_size returns to 256, then a clearing pass over all 256 blocks zeroes the map
//   while req ready stays low
module disk_block_allocator (
	input  logic       clk,
	input  logic       arst_n,
	dba_req_if.sink    req,
	dba_rsp_if.source  rsp,
	dba_cfg_if.sink    cfg
);

	logic [dba_pkg::SIZE_W-1:0]  disk_size_q;
	logic [dba_pkg::CNT_W-1:0]   disk_n;
	dba_pkg::map_req_t           map_req;
	dba_pkg::fnd_req_t           fnd_req;
	logic                        map_rdata;
	logic [dba_pkg::BLK_W-1:0]   fnd_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_size_q <= dba_pkg::SIZE_W'(dba_pkg::SIZE_RESET);
		end else if (cfg.valid && cfg.ready) begin
			disk_size_q <= cfg.data;
		end
	end

	// effective size never exceeds the map
	assign disk_n = (disk_size_q > dba_pkg::SIZE_W'(dba_pkg::NUM_BLOCKS))
		? dba_pkg::CNT_W'(dba_pkg::NUM_BLOCKS) : dba_pkg::CNT_W'(disk_size_q);

	dba_ram #(
		.WIDTH (1),
		.DEPTH (dba_pkg::NUM_BLOCKS)
	) u_map (
		.clk   (clk),
		.we    (map_req.we),
		.waddr (map_req.waddr),
		.wdata (map_req.wdata),
		.raddr (map_req.raddr),
		.rdata (map_rdata)
	);

	dba_ram #(
		.WIDTH (dba_pkg::BLK_W),
		.DEPTH (dba_pkg::MAX_RUN)
	) u_found (
		.clk   (clk),
		.we    (fnd_req.we),
		.waddr (fnd_req.waddr),
		.wdata (fnd_req.wdata),
		.raddr (fnd_req.raddr),
		.rdata (fnd_rdata)
	);

	dba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.disk_n    (disk_n),
		.map_req   (map_req),
		.map_rdata (map_rdata),
		.fnd_req   (fnd_req),
		.fnd_rdata (fnd_rdata)
	);

endmodule

// File: verif/disk_block_allocator_tb.sv
`timescale 1ns / 1ps

module disk_block_allocator_tb;

	localparam int FIRST_UNUSED_OP  = dba_pkg::OP_READ + 1;
	localparam int OP_CODES         = 1 << dba_pkg::OP_W;
	localparam int RANDOM_PER_PHASE = 20;
	localparam int TAIL_CYCLES      = 300;

	typedef enum {STALL_NONE, STALL_HEAVY, STALL_LIGHT} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic sink_ready = 1'b0;

	dba_req_if req ();
	dba_rsp_if rsp ();
	dba_cfg_if cfg ();

	disk_block_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	assign rsp.ready = sink_ready;

	always #1 clk = ~clk;

	// mirror of the allocator state
	bit [dba_pkg::NUM_BLOCKS-1:0]   block_used;
	logic [dba_pkg::SIZE_W-1:0]     disk_size;
	dba_pkg::res_t                  pending_beats[$];
	int                             mismatch_count = 0;
	int                             burst_left = 0;

	// receiver stall pattern
	logic [31:0] stall_word;
	int          stall_phase = 0;
	stall_mode_t stall_mode = STALL_NONE;

	always @(negedge clk) begin
		if (stall_phase == 0) begin
			stall_word = $urandom;
			stall_mode = stall_mode_t'($urandom_range(0, 2));
		end
		case (stall_mode)
			STALL_NONE: begin
				sink_ready <= 1'b1;
			end
			STALL_HEAVY: begin
				sink_ready <= stall_word[stall_phase];
			end
			default: begin
				sink_ready <= stall_word[stall_phase] | stall_word[(stall_phase + 7) % 32];
			end
		endcase
		stall_phase = (stall_phase + 1) % 32;
	end

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic int usable_blocks();
		return (disk_size < dba_pkg::NUM_BLOCKS) ? int'(disk_size) : dba_pkg::NUM_BLOCKS;
	endfunction

	function automatic void expect_beat(logic status, dba_pkg::kind_t kind, int blk, int nxt,
		logic has_next, logic mark, logic last);
		dba_pkg::res_t beat;
		beat.status     = status;
		beat.kind       = kind;
		beat.block      = dba_pkg::BLK_W'(blk);
		beat.next_block = dba_pkg::BLK_W'(nxt);
		beat.has_next   = has_next;
		beat.mark       = mark;
		beat.last       = last;
		pending_beats.push_back(beat);
	endfunction

	function automatic void expect_failure();
		expect_beat(1'b1, dba_pkg::KIND_NONE, 0, 0, 1'b0, 1'b0, 1'b1);
	endfunction

	// first len free blocks below span, passing over skip
	function automatic bit find_free(int span, int len, int skip, ref int picked[$]);
		picked.delete();
		for (int i = 0; i < span && picked.size() < len; i++)
			if (!block_used[i] && i != skip)
				picked.push_back(i);
		return picked.size() >= len;
	endfunction

	function automatic void predict_request(logic [dba_pkg::OP_W-1:0] op,
		logic [dba_pkg::BLK_W-1:0] bn, logic [dba_pkg::LEN_W-1:0] len, logic mv);
		int span;
		int first;
		int count;
		int picked[$];
		bit clash;
		span  = usable_blocks();
		first = int'(bn);
		count = int'(len);
		case (op)
			dba_pkg::OP_SET: begin
				block_used[first] = mv;
			end
			dba_pkg::OP_READ: begin
				expect_beat(1'b0, dba_pkg::KIND_MARK, first, 0, 1'b0, block_used[first], 1'b1);
			end
			dba_pkg::OP_CONTIG: begin
				clash = (span == 0) || (first + count > span);
				for (int i = 0; i < count && !clash; i++)
					clash = block_used[first + i];
				if (clash) begin
					expect_failure();
				end else if (count == 0) begin
					expect_beat(1'b0, dba_pkg::KIND_NONE, 0, 0, 1'b0, 1'b0, 1'b1);
				end else begin
					for (int i = 0; i < count; i++) begin
						block_used[first + i] = 1'b1;
						expect_beat(1'b0, dba_pkg::KIND_DATA, first + i, 0, 1'b0, 1'b0,
							i == count - 1);
					end
				end
			end
			dba_pkg::OP_INDEXED: begin
				if (first >= span || block_used[first]
					|| !find_free(span, count, first, picked)) begin
					expect_failure();
				end else begin
					block_used[first] = 1'b1;
					expect_beat(1'b0, dba_pkg::KIND_INDEX, first, 0, 1'b0, 1'b0, count == 0);
					foreach (picked[i]) begin
						block_used[picked[i]] = 1'b1;
						expect_beat(1'b0, dba_pkg::KIND_DATA, picked[i], 0, 1'b0, 1'b0,
							i == count - 1);
					end
				end
			end
			dba_pkg::OP_LINKED: begin
				if (count == 0 || span == 0
					|| !find_free(span, count, dba_pkg::NUM_BLOCKS, picked)) begin
					expect_failure();
				end else begin
					foreach (picked[i]) begin
						block_used[picked[i]] = 1'b1;
						if (i + 1 < count)
							expect_beat(1'b0, dba_pkg::KIND_DATA, picked[i], picked[i + 1],
								1'b1, 1'b0, 1'b0);
						else
							expect_beat(1'b0, dba_pkg::KIND_DATA, picked[i], 0, 1'b0, 1'b0,
								1'b1);
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic check_field(string name, logic [dba_pkg::BLK_W-1:0] got,
		logic [dba_pkg::BLK_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	always @(posedge clk) begin
		dba_pkg::res_t want;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, block %0d", rsp.block));
			end else begin
				want = pending_beats.pop_front();
				check_field("status", dba_pkg::BLK_W'(rsp.status),
					dba_pkg::BLK_W'(want.status));
				check_field("kind", dba_pkg::BLK_W'(rsp.kind), dba_pkg::BLK_W'(want.kind));
				check_field("block", rsp.block, want.block);
				check_field("next_block", rsp.next_block, want.next_block);
				check_field("has_next", dba_pkg::BLK_W'(rsp.has_next),
					dba_pkg::BLK_W'(want.has_next));
				check_field("mark", dba_pkg::BLK_W'(rsp.mark), dba_pkg::BLK_W'(want.mark));
				check_field("last", dba_pkg::BLK_W'(rsp.last), dba_pkg::BLK_W'(want.last));
			end
		end
	end

	task automatic idle_sender(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			req.valid <= 1'b0;
		end
	endtask

	task automatic pace_sender();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			if ($urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 6));
		end
		burst_left--;
	endtask

	task automatic send_request(logic [dba_pkg::OP_W-1:0] op, logic [dba_pkg::BLK_W-1:0] bn,
		logic [dba_pkg::LEN_W-1:0] len, logic mv);
		pace_sender();
		@(negedge clk);
		req.valid        <= 1'b1;
		req.operation    <= op;
		req.block_number <= bn;
		req.length       <= len;
		req.mark_value   <= mv;
		do begin
			@(posedge clk);
		end while (!req.ready);
		predict_request(op, bn, len, mv);
	endtask

	// all beats in, block back to idle
	task automatic settle();
		idle_sender(1);
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic write_disk_size(logic [dba_pkg::SIZE_W-1:0] value);
		settle();
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg.ready);
		disk_size = value;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic test_mark_access();
		send_request(dba_pkg::OP_READ, 8'd0, 6'd0, 1'b1);
		send_request(dba_pkg::OP_SET, 8'd0, 6'd63, 1'b1);
		send_request(dba_pkg::OP_READ, 8'd0, 6'd0, 1'b0);
		send_request(dba_pkg::OP_SET, 8'd255, 6'd0, 1'b1);
		send_request(dba_pkg::OP_READ, 8'd255, 6'd63, 1'b0);
		// undefined operation codes are dropped without a beat
		for (int op = FIRST_UNUSED_OP; op < OP_CODES; op++)
			send_request(dba_pkg::OP_W'(op), dba_pkg::BLK_W'($urandom),
				dba_pkg::LEN_W'($urandom), 1'($urandom));
	endtask

	task automatic test_contiguous();
		send_request(dba_pkg::OP_CONTIG, 8'd0, 6'd0, 1'b0);
		send_request(dba_pkg::OP_CONTIG, 8'd0, 6'd4, 1'b0);
		send_request(dba_pkg::OP_CONTIG, 8'd1, 6'd63, 1'b0);
		send_request(dba_pkg::OP_CONTIG, 8'd193, 6'd63, 1'b0);
		send_request(dba_pkg::OP_SET, 8'd255, 6'd0, 1'b0);
		// run ending on the last block of the disk
		send_request(dba_pkg::OP_CONTIG, 8'd193, 6'd63, 1'b1);
		send_request(dba_pkg::OP_CONTIG, 8'd200, 6'd57, 1'b0);
	endtask

	task automatic test_indexed();
		send_request(dba_pkg::OP_INDEXED, 8'd100, 6'd0, 1'b0);
		send_request(dba_pkg::OP_INDEXED, 8'd100, 6'd3, 1'b0);
		send_request(dba_pkg::OP_INDEXED, 8'd150, 6'd63, 1'b0);
	endtask

	task automatic test_linked();
		send_request(dba_pkg::OP_LINKED, 8'd7, 6'd0, 1'b0);
		send_request(dba_pkg::OP_LINKED, 8'd0, 6'd1, 1'b0);
		send_request(dba_pkg::OP_LINKED, 8'd0, 6'd63, 1'b0);
		send_request(dba_pkg::OP_LINKED, 8'd0, 6'd1, 1'b0);
	endtask

	task automatic test_disk_size();
		write_disk_size('0);
		send_request(dba_pkg::OP_CONTIG, 8'd0, 6'd0, 1'b0);
		send_request(dba_pkg::OP_INDEXED, 8'd0, 6'd0, 1'b0);
		send_request(dba_pkg::OP_LINKED, 8'd0, 6'd1, 1'b0);
		send_request(dba_pkg::OP_READ, 8'd255, 6'd0, 1'b0);
		write_disk_size(9'd1);
		send_request(dba_pkg::OP_SET, 8'd0, 6'd0, 1'b0);
		send_request(dba_pkg::OP_CONTIG, 8'd0, 6'd1, 1'b0);
		send_request(dba_pkg::OP_LINKED, 8'd0, 6'd2, 1'b0);
	endtask

	task automatic random_request();
		int span;
		int used_here;
		int pick;
		int held[$];
		logic [dba_pkg::OP_W-1:0]  op;
		logic [dba_pkg::BLK_W-1:0] bn;
		logic [dba_pkg::LEN_W-1:0] len;
		logic                      mv;
		span      = usable_blocks();
		used_here = 0;
		for (int i = 0; i < dba_pkg::NUM_BLOCKS; i++) begin
			if (block_used[i]) begin
				held.push_back(i);
				if (i < span)
					used_here++;
			end
		end
		if (span > 0 && $urandom_range(0, 4) != 0)
			bn = dba_pkg::BLK_W'($urandom_range(0, span - 1));
		else
			bn = dba_pkg::BLK_W'($urandom);
		if ($urandom_range(0, 7) == 0)
			len = dba_pkg::LEN_W'($urandom);
		else
			len = dba_pkg::LEN_W'($urandom_range(0, 6));
		mv   = 1'($urandom);
		pick = $urandom_range(0, 99);
		// release a held block, more often once the disk fills up
		if (held.size() > 0 && (pick < 20 || (used_here * 2 > span && pick < 55))) begin
			op = dba_pkg::OP_SET;
			bn = dba_pkg::BLK_W'(held[$urandom_range(0, held.size() - 1)]);
			mv = 1'b0;
		end else if (pick < 27) begin
			op = dba_pkg::OP_SET;
		end else if (pick < 40) begin
			op = dba_pkg::OP_READ;
		end else if (pick < 58) begin
			op = dba_pkg::OP_CONTIG;
		end else if (pick < 75) begin
			op = dba_pkg::OP_INDEXED;
		end else if (pick < 95) begin
			op = dba_pkg::OP_LINKED;
		end else begin
			op = dba_pkg::OP_W'($urandom_range(FIRST_UNUSED_OP, OP_CODES - 1));
		end
		send_request(op, bn, len, mv);
	endtask

	task automatic test_random_traffic();
		int size_plan[7];
		size_plan = '{dba_pkg::SIZE_RESET, 1, 40, 511, 2, 129, 0};
		size_plan[6] = $urandom_range(1, 511);
		foreach (size_plan[p]) begin
			write_disk_size(dba_pkg::SIZE_W'(size_plan[p]));
			repeat (RANDOM_PER_PHASE) random_request();
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.operation    = dba_pkg::OP_SET;
		req.block_number = '0;
		req.length       = '0;
		req.mark_value   = 1'b0;
		cfg.valid        = 1'b0;
		cfg.data         = '0;
		block_used       = '0;
		disk_size        = dba_pkg::SIZE_W'(dba_pkg::SIZE_RESET);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_mark_access();
		test_contiguous();
		test_indexed();
		test_linked();
		test_disk_size();
		test_random_traffic();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_beats.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: disk_block_allocator.f
hdl/dba_pkg.sv
hdl/dba_req_if.sv
hdl/dba_rsp_if.sv
hdl/dba_cfg_if.sv
hdl/dba_ram.sv
hdl/dba_ctrl.sv
hdl/disk_block_allocator.sv
verif/disk_block_allocator_tb.sv
